// ----- hdl/itas_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// itas_pkg
// Shared widths, side-band record and arctangent step table for the inertial
// scaling and tilt pipeline.
// ----------------------------------------------------------------------------
package itas_pkg;

  localparam int RawW   = 16;
  localparam int MgW    = 12;
  localparam int CdpsW  = 16;
  localparam int TiltW  = 15;

  // Square root of (ay^2 + az^2) * 2^16, two result bits per stage.
  localparam int SumW         = 32;
  localparam int NumW         = SumW + 16;
  localparam int RootW        = NumW / 2;
  localparam int RemW         = RootW + 2;
  localparam int SqrtPerStage = 2;
  localparam int SqrtStages   = RootW / SqrtPerStage;

  // Vectoring rotator.
  localparam int CordW     = 27;
  localparam int AngW      = 26;
  localparam int AtanW     = 23;
  localparam int CordSteps = 20;
  localparam int TiltMax   = 9000;

  // floor(2^32 / 262), used for the rate conversion with one correction step.
  localparam logic [23:0] CdpsRecip = 24'd16393004;

  typedef struct packed {
    logic signed [MgW-1:0]   accel_x_mg;
    logic signed [MgW-1:0]   accel_y_mg;
    logic signed [MgW-1:0]   accel_z_mg;
    logic signed [CdpsW-1:0] rate_x_cdps;
    logic signed [CdpsW-1:0] rate_y_cdps;
    logic signed [CdpsW-1:0] rate_z_cdps;
    logic signed [RawW-1:0]  ax;
    logic                    ax_zero;
    logic                    s_zero;
  } side_t;

  // atan(2^-i) in units of 1/1024 hundredth of a degree.
  function automatic logic [AtanW-1:0] atan_step(input int unsigned idx);
    logic [AtanW-1:0] val;
    unique case (idx)
      0:       val = 23'd4608000;
      1:       val = 23'd2720261;
      2:       val = 23'd1437311;
      3:       val = 23'd729602;
      4:       val = 23'd366217;
      5:       val = 23'd183287;
      6:       val = 23'd91666;
      7:       val = 23'd45836;
      8:       val = 23'd22918;
      9:       val = 23'd11459;
      10:      val = 23'd5730;
      11:      val = 23'd2865;
      12:      val = 23'd1432;
      13:      val = 23'd716;
      14:      val = 23'd358;
      15:      val = 23'd179;
      16:      val = 23'd90;
      17:      val = 23'd45;
      18:      val = 23'd22;
      19:      val = 23'd11;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/itas_sqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// itas_sqrt
// Pipelined digit-by-digit integer square root of the sum scaled by 2^16,
// two root bits per stage, carrying the side-band record alongside.
// ----------------------------------------------------------------------------
module itas_sqrt import itas_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [SumW-1:0]  in_sum,
  input  side_t            in_side,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [RootW-1:0] out_root,
  output side_t            out_side
);

  logic             v    [SqrtStages];
  logic             en   [SqrtStages+1];
  logic [RemW-1:0]  rem  [SqrtStages];
  logic [RootW-1:0] root [SqrtStages];
  logic [SumW-1:0]  sum  [SqrtStages];
  side_t            side [SqrtStages];

  assign en[SqrtStages] = out_ready;

  for (genvar k = 0; k < SqrtStages; k++) begin : g_stage
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [SumW-1:0]  sum_in;
    side_t            side_in;
    logic             valid_in;
    logic [NumW-1:0]  num;
    logic [RemW-1:0]  rem_w  [SqrtPerStage+1];
    logic [RootW-1:0] root_w [SqrtPerStage+1];

    if (k == 0) begin : g_first
      assign rem_in   = '0;
      assign root_in  = '0;
      assign sum_in   = in_sum;
      assign side_in  = in_side;
      assign valid_in = in_valid;
    end else begin : g_next
      assign rem_in   = rem[k-1];
      assign root_in  = root[k-1];
      assign sum_in   = sum[k-1];
      assign side_in  = side[k-1];
      assign valid_in = v[k-1];
    end

    assign num       = {sum_in, {(NumW-SumW){1'b0}}};
    assign rem_w[0]  = rem_in;
    assign root_w[0] = root_in;

    for (genvar j = 0; j < SqrtPerStage; j++) begin : g_iter
      localparam int Pos = NumW - 2 - 2 * (SqrtPerStage * k + j);
      logic [RemW+1:0] rem_sh;
      logic [RemW+1:0] trial;
      logic            ge;

      // Bring down the next pair of radicand bits and try the next root bit.
      assign rem_sh        = {rem_w[j], num[Pos +: 2]};
      assign trial         = {2'b00, root_w[j], 2'b01};
      assign ge            = rem_sh >= trial;
      assign rem_w[j+1]    = ge ? RemW'(rem_sh - trial) : RemW'(rem_sh);
      assign root_w[j+1]   = {root_w[j][RootW-2:0], ge};
    end

    assign en[k] = !v[k] || en[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem[k]  <= rem_w[SqrtPerStage];
        root[k] <= root_w[SqrtPerStage];
        sum[k]  <= sum_in;
        side[k] <= side_in;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[SqrtStages-1];
  assign out_root  = root[SqrtStages-1];
  assign out_side  = side[SqrtStages-1];

  a_rem_bound : assert property (@(posedge clk) disable iff (rst)
    v[SqrtStages-1] |->
      ({1'b0, rem[SqrtStages-1]} <= {2'b00, root[SqrtStages-1], 1'b0}))
    else $error("square root remainder exceeds twice the root");

  a_enter : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v[0])
    else $error("accepted request did not reach the first root stage");

endmodule
`default_nettype wire

// ----- hdl/itas_cordic.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// itas_cordic
// Vectoring rotator, one step per stage, followed by rounding, clamping and
// the zero-axis cases in the output register.
// ----------------------------------------------------------------------------
module itas_cordic import itas_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [RootW-1:0]        in_root,
  input  side_t                   in_side,
  output logic                    out_valid,
  input  logic                    out_ready,
  output side_t                   out_side,
  output logic signed [TiltW-1:0] out_tilt
);

  logic                   v    [CordSteps];
  logic                   en   [CordSteps+1];
  logic signed [CordW-1:0] a   [CordSteps];
  logic signed [CordW-1:0] b   [CordSteps];
  logic signed [AngW-1:0]  ang [CordSteps];
  side_t                  side [CordSteps];

  logic signed [AngW-1:0]     ang_rnd;
  logic signed [AngW-11:0]    ang_q;
  logic signed [TiltW-1:0]    tilt_next;
  side_t                      last_side;

  assign en[CordSteps] = !out_valid || out_ready;

  for (genvar k = 0; k < CordSteps; k++) begin : g_step
    logic signed [CordW-1:0] a_in;
    logic signed [CordW-1:0] b_in;
    logic signed [AngW-1:0]  ang_in;
    side_t                   side_in;
    logic                    valid_in;
    logic signed [AngW-1:0]  step_ang;
    logic                    up;

    if (k == 0) begin : g_first
      assign a_in     = $signed({{(CordW-RootW){1'b0}}, in_root});
      assign b_in     = $signed({{(CordW-RawW-8){in_side.ax[RawW-1]}}, in_side.ax, 8'b0});
      assign ang_in   = '0;
      assign side_in  = in_side;
      assign valid_in = in_valid;
    end else begin : g_next
      assign a_in     = a[k-1];
      assign b_in     = b[k-1];
      assign ang_in   = ang[k-1];
      assign side_in  = side[k-1];
      assign valid_in = v[k-1];
    end

    assign step_ang = $signed({{(AngW-AtanW){1'b0}}, atan_step(k)});
    assign up       = b_in > 0;
    assign en[k]    = !v[k] || en[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        if (up) begin
          a[k]   <= a_in + (b_in >>> k);
          b[k]   <= b_in - (a_in >>> k);
          ang[k] <= ang_in + step_ang;
        end else begin
          a[k]   <= a_in - (b_in >>> k);
          b[k]   <= b_in + (a_in >>> k);
          ang[k] <= ang_in - step_ang;
        end
        side[k] <= side_in;
      end
    end
  end

  assign last_side = side[CordSteps-1];
  assign ang_rnd   = ang[CordSteps-1] + AngW'(512);
  assign ang_q     = ang_rnd[AngW-1:10];

  always_comb begin
    priority if (last_side.ax_zero) begin
      tilt_next = '0;
    end else if (last_side.s_zero) begin
      tilt_next = last_side.ax[RawW-1] ? TiltW'(-TiltMax) : TiltW'(TiltMax);
    end else if (ang_q > TiltMax) begin
      tilt_next = TiltW'(TiltMax);
    end else if (ang_q < -TiltMax) begin
      tilt_next = TiltW'(-TiltMax);
    end else begin
      tilt_next = TiltW'(ang_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en[CordSteps]) begin
      out_valid <= v[CordSteps-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[CordSteps]) begin
      out_side <= last_side;
      out_tilt <= tilt_next;
    end
  end

  assign in_ready = en[0];

  a_tilt_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_tilt <= TiltMax && out_tilt >= -TiltMax))
    else $error("tilt outside the clamp range");

  a_mag_positive : assert property (@(posedge clk) disable iff (rst)
    v[CordSteps-1] |-> !a[CordSteps-1][CordW-1])
    else $error("rotator magnitude went negative");

endmodule
`default_nettype wire

// ----- hdl/imu_tilt_and_scaling.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// imu_tilt_and_scaling
// Scales one raw six-axis inertial sample to milli-g and hundredths of a
// degree per second, and derives the accelerometer tilt angle.
// ----------------------------------------------------------------------------
// Usage: one request on s_axis carries a whole raw sample; one request on
// m_axis carries the scaled sample and the tilt for it, in the same order.
// Between acceptance on s_axis and acceptance on m_axis lie three scaling
// stages, twelve square-root stages (two root bits each), twenty rotator
// stages and the output register. Every stage holds one request, so while
// m_axis_tready is high it takes a request every cycle; the sustained rate
// is then one sample per cycle.
// When the receiver holds m_axis_tready low, the result stays in the output
// register and the stages behind it keep filling until each holds a request;
// only then does s_axis_tready fall. Nothing is dropped or repeated.
// Synchronous reset empties every stage; payload registers are not cleared.
// Tilt is 0 when the x axis is zero and +/-9000 when y and z are both zero.
// ----------------------------------------------------------------------------
module imu_tilt_and_scaling import itas_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // accel_x_mg, accel_y_mg, accel_z_mg, rate_x_cdps, rate_y_cdps,
  // rate_z_cdps, tilt_cdeg, five zero bits
  output logic [103:0] m_axis_tdata
);

  logic signed [RawW-1:0] raw [6];
  logic [RawW:0]          mag [6];
  logic signed [MgW-1:0]  mg_val [3];
  logic [22:0]            cn_val [3];

  // Stage A: squares, milli-g and the rate numerators.
  logic                   a_valid;
  logic [30:0]            a_sq_y;
  logic [30:0]            a_sq_z;
  logic signed [RawW-1:0] a_ax;
  logic signed [MgW-1:0]  a_mg [3];
  logic [22:0]            a_cn [3];
  logic                   a_neg [3];

  // Stage B: sum of squares and the reciprocal estimate of each rate.
  logic                   b_valid;
  logic [SumW-1:0]        b_s;
  logic signed [RawW-1:0] b_ax;
  logic signed [MgW-1:0]  b_mg [3];
  logic [22:0]            b_cn [3];
  logic [14:0]            b_q0 [3];
  logic                   b_neg [3];

  // Stage C: corrected rates, record ready for the root.
  logic                   c_valid;
  logic [SumW-1:0]        c_s;
  side_t                  c_side;

  logic signed [CdpsW-1:0] rate_val [3];
  logic                    en_a;
  logic                    en_b;
  logic                    en_c;
  logic                    sq_ready;
  logic                    sq_valid;
  logic [RootW-1:0]        sq_root;
  side_t                   sq_side;
  logic                    co_ready;
  side_t                   o_side;
  logic signed [TiltW-1:0] o_tilt;

  for (genvar k = 0; k < 6; k++) begin : g_unpack
    assign raw[k] = $signed(s_axis_tdata[RawW*k +: RawW]);
    assign mag[k] = raw[k][RawW-1] ? (RawW+1)'(-$signed({raw[k][RawW-1], raw[k]}))
                                   : (RawW+1)'({1'b0, raw[k]});
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [22:0] mg_sum;
      mg_sum    = 23'(mag[i]) * 23'd125 + 23'd1024;
      mg_val[i] = raw[i][RawW-1] ? -$signed(MgW'(mg_sum[22:11]))
                                 : $signed(MgW'(mg_sum[22:11]));
      cn_val[i] = 23'(mag[i+3]) * 23'd200 + 23'd131;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [22:0] rem;
      logic [CdpsW-1:0] q;
      // The estimate is low by at most one; one compare settles it.
      rem = b_cn[i] - 23'(b_q0[i]) * 23'd262;
      q   = CdpsW'(b_q0[i]) + CdpsW'(rem >= 23'd262);
      rate_val[i] = b_neg[i] ? -$signed(q) : $signed(q);
    end
  end

  assign en_c          = !c_valid || sq_ready;
  assign en_b          = !b_valid || en_c;
  assign en_a          = !a_valid || en_b;
  assign s_axis_tready = en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (en_a) begin
        a_valid <= s_axis_tvalid;
      end
      if (en_b) begin
        b_valid <= a_valid;
      end
      if (en_c) begin
        c_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_sq_y <= 31'(32'(mag[1]) * 32'(mag[1]));
      a_sq_z <= 31'(32'(mag[2]) * 32'(mag[2]));
      a_ax   <= raw[0];
      for (int i = 0; i < 3; i++) begin
        a_mg[i]  <= mg_val[i];
        a_cn[i]  <= cn_val[i];
        a_neg[i] <= raw[i+3][RawW-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_s  <= SumW'(a_sq_y) + SumW'(a_sq_z);
      b_ax <= a_ax;
      for (int i = 0; i < 3; i++) begin
        logic [46:0] prod;
        prod     = 47'(a_cn[i]) * 47'(CdpsRecip);
        b_q0[i]  <= prod[46:32];
        b_mg[i]  <= a_mg[i];
        b_cn[i]  <= a_cn[i];
        b_neg[i] <= a_neg[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_s                <= b_s;
      c_side.accel_x_mg  <= b_mg[0];
      c_side.accel_y_mg  <= b_mg[1];
      c_side.accel_z_mg  <= b_mg[2];
      c_side.rate_x_cdps <= rate_val[0];
      c_side.rate_y_cdps <= rate_val[1];
      c_side.rate_z_cdps <= rate_val[2];
      c_side.ax          <= b_ax;
      c_side.ax_zero     <= (b_ax == '0);
      c_side.s_zero      <= (b_s == '0);
    end
  end

  itas_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid),
    .in_ready  (sq_ready),
    .in_sum    (c_s),
    .in_side   (c_side),
    .out_valid (sq_valid),
    .out_ready (co_ready),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  itas_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_ready  (co_ready),
    .in_root   (sq_root),
    .in_side   (sq_side),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_side  (o_side),
    .out_tilt  (o_tilt)
  );

  assign m_axis_tdata = {5'b00000, o_tilt,
                         o_side.rate_z_cdps, o_side.rate_y_cdps, o_side.rate_x_cdps,
                         o_side.accel_z_mg, o_side.accel_y_mg, o_side.accel_x_mg};

  a_enter : assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> a_valid)
    else $error("accepted request did not reach the first stage");

  a_mg_range : assert property (@(posedge clk) disable iff (rst)
    a_valid |-> (a_mg[0] <= 2000 && a_mg[0] >= -2000
              && a_mg[1] <= 2000 && a_mg[1] >= -2000
              && a_mg[2] <= 2000 && a_mg[2] >= -2000))
    else $error("milli-g value outside the two-g range");

endmodule
`default_nettype wire
